// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files.
// Included by bare file name; empty bodies when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SMA_ASSERT_IMPL(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed: same-cycle implication");
`define SMA_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed: next-cycle implication");
`else
`define SMA_ASSERT_IMPL(label, clk, rst, cond, prop)
`define SMA_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif
`endif

// ===== rtl/sma_pkg.sv =====
// Shared types, codes and constants of the split memory access unit.
// No dependencies; used by every other RTL file but the assertion macros.
package sma_pkg;

  localparam int MEMORY_BYTES_DEFAULT = 131072;

  localparam int ADDR_W   = 17;
  localparam int DATA_W   = 16;
  localparam int BYTE_W   = 8;
  localparam int LEN_W    = 18;
  localparam int BASE_W   = 17;
  localparam int SIZE_W   = 18;
  localparam int CFG_W    = 18;
  localparam int OP_W     = 3;
  localparam int STATUS_W = 2;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [BASE_W-1:0] STATIC_BASE_RESET = 17'd64;
  localparam logic [SIZE_W-1:0] IMAGE_SIZE_RESET  = 18'd131072;

  localparam logic CFG_STATIC_BASE = 1'b0;
  localparam logic CFG_IMAGE_SIZE  = 1'b1;

  localparam logic [OP_W-1:0] OP_LOAD       = 3'd0;
  localparam logic [OP_W-1:0] OP_READ_BYTE  = 3'd1;
  localparam logic [OP_W-1:0] OP_READ_WORD  = 3'd2;
  localparam logic [OP_W-1:0] OP_WRITE_BYTE = 3'd3;
  localparam logic [OP_W-1:0] OP_WRITE_WORD = 3'd4;
  localparam logic [OP_W-1:0] OP_COPY       = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BOUNDS   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_PROTECT  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ZERO_LEN = 2'd3;

  typedef enum logic [2:0] {
    CMD_NONE        = 3'd0,
    CMD_WRITE_BYTE  = 3'd1,
    CMD_WRITE_WORD  = 3'd2,
    CMD_READ_BYTE   = 3'd3,
    CMD_READ_WORD   = 3'd4,
    CMD_COPY        = 3'd5
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t             kind;
    logic [STATUS_W-1:0]   status;
    logic                  in_dynamic;
    logic [ADDR_W-1:0]     address;
    logic [ADDR_W-1:0]     source_address;
    logic [DATA_W-1:0]     write_data;
    logic [LEN_W-1:0]      copy_length;
  } cmd_t;

endpackage

// ===== rtl/sma_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// Read of the address being written returns the new data. Defaults from sma_pkg.
module sma_ram #(
  parameter int WIDTH = sma_pkg::BYTE_W,
  parameter int DEPTH = sma_pkg::MEMORY_BYTES_DEFAULT
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= (we && (waddr == raddr)) ? wdata : mem[raddr];
    end
  end

endmodule

// ===== rtl/sma_front.sv =====
// Front end: takes requests, checks bounds and protection in two stages
// and issues commands. Depends on sma_pkg.
module sma_front #(
  parameter int MEMORY_BYTES = sma_pkg::MEMORY_BYTES_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [sma_pkg::OP_W-1:0]      operation,
  input  logic [sma_pkg::ADDR_W-1:0]    address,
  input  logic [sma_pkg::ADDR_W-1:0]    source_address,
  input  logic [sma_pkg::DATA_W-1:0]    write_data,
  input  logic [sma_pkg::LEN_W-1:0]     copy_length,
  input  logic [sma_pkg::BASE_W-1:0]    static_base,
  input  logic [sma_pkg::SIZE_W-1:0]    image_size,
  output logic                          cmd_valid,
  output sma_pkg::cmd_t                 cmd,
  input  logic                          cmd_full
);

  localparam int SW = sma_pkg::SIZE_W;
  localparam int LW = sma_pkg::LEN_W;
  localparam int BW = sma_pkg::BASE_W;

  // stage A: registered request
  logic                        a_valid;
  logic [sma_pkg::OP_W-1:0]    a_op;
  logic [sma_pkg::ADDR_W-1:0]  a_addr;
  logic [sma_pkg::ADDR_W-1:0]  a_src;
  logic [sma_pkg::DATA_W-1:0]  a_data;
  logic [LW-1:0]               a_len;

  // stage B: request plus distances to the limits
  logic                        b_valid;
  logic [sma_pkg::OP_W-1:0]    b_op;
  logic [sma_pkg::ADDR_W-1:0]  b_addr;
  logic [sma_pkg::ADDR_W-1:0]  b_src;
  logic [sma_pkg::DATA_W-1:0]  b_data;
  logic [LW-1:0]               b_len;
  logic [SW-1:0]               b_dsrc;
  logic [SW-1:0]               b_ddst;
  logic [BW-1:0]               b_dprot;

  logic                        a_adv;
  logic                        b_adv;
  logic [SW-1:0]               lim;
  logic [SW-1:0]               a_src_ext;
  logic [SW-1:0]               a_addr_ext;
  logic [SW-1:0]               dsrc;
  logic [SW-1:0]               ddst;
  logic [BW-1:0]               dprot;

  logic                        use_src;
  logic                        use_prot;
  logic                        known;
  logic [LW-1:0]               need;
  sma_pkg::cmd_kind_t          kind_ok;
  logic [SW-1:0]               bmin;
  logic [SW-1:0]               prot_ext;
  logic                        bounds_err;
  logic                        prot_err;
  logic [sma_pkg::STATUS_W-1:0] status_b;

  assign b_adv     = !b_valid || !cmd_full;
  assign a_adv     = !a_valid || b_adv;
  assign req_stall = !a_adv;

  assign lim = (32'(image_size) < 32'(MEMORY_BYTES)) ? image_size : SW'(MEMORY_BYTES);
  assign a_src_ext  = SW'(a_src);
  assign a_addr_ext = SW'(a_addr);
  assign dsrc  = (a_src_ext >= lim)  ? '0 : lim - a_src_ext;
  assign ddst  = (a_addr_ext >= lim) ? '0 : lim - a_addr_ext;
  assign dprot = (a_addr >= static_base) ? '0 : static_base - a_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (a_adv) begin
        a_valid <= req_valid;
      end
      if (b_adv) begin
        b_valid <= a_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv && req_valid) begin
      a_op   <= operation;
      a_addr <= address;
      a_src  <= source_address;
      a_data <= write_data;
      a_len  <= copy_length;
    end
    if (b_adv && a_valid) begin
      b_op    <= a_op;
      b_addr  <= a_addr;
      b_src   <= a_src;
      b_data  <= a_data;
      b_len   <= a_len;
      b_dsrc  <= dsrc;
      b_ddst  <= ddst;
      b_dprot <= dprot;
    end
  end

  always_comb begin
    use_src  = 1'b0;
    use_prot = 1'b0;
    known    = 1'b1;
    need     = LW'(1);
    kind_ok  = sma_pkg::CMD_NONE;
    case (b_op)
      sma_pkg::OP_LOAD: begin
        kind_ok = sma_pkg::CMD_WRITE_BYTE;
      end
      sma_pkg::OP_READ_BYTE: begin
        kind_ok = sma_pkg::CMD_READ_BYTE;
      end
      sma_pkg::OP_READ_WORD: begin
        need    = LW'(2);
        kind_ok = sma_pkg::CMD_READ_WORD;
      end
      sma_pkg::OP_WRITE_BYTE: begin
        use_prot = 1'b1;
        kind_ok  = sma_pkg::CMD_WRITE_BYTE;
      end
      sma_pkg::OP_WRITE_WORD: begin
        use_prot = 1'b1;
        need     = LW'(2);
        kind_ok  = sma_pkg::CMD_WRITE_WORD;
      end
      sma_pkg::OP_COPY: begin
        use_src  = 1'b1;
        use_prot = 1'b1;
        need     = b_len;
        kind_ok  = sma_pkg::CMD_COPY;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  // first failing offset decides: bounds wins a tie with protection
  assign bmin       = (use_src && (b_dsrc < b_ddst)) ? b_dsrc : b_ddst;
  assign prot_ext   = SW'(b_dprot);
  assign bounds_err = (bmin < need) && (!use_prot || (bmin <= prot_ext));
  assign prot_err   = use_prot && (prot_ext < need);

  always_comb begin
    if (!known) begin
      status_b = sma_pkg::ST_OK;
    end else if ((b_op == sma_pkg::OP_COPY) && (b_len == '0)) begin
      status_b = sma_pkg::ST_ZERO_LEN;
    end else if (bounds_err) begin
      status_b = sma_pkg::ST_BOUNDS;
    end else if (prot_err) begin
      status_b = sma_pkg::ST_PROTECT;
    end else begin
      status_b = sma_pkg::ST_OK;
    end
  end

  assign cmd_valid           = b_valid;
  assign cmd.kind            = (known && (status_b == sma_pkg::ST_OK)) ? kind_ok
                                                                      : sma_pkg::CMD_NONE;
  assign cmd.status          = status_b;
  assign cmd.in_dynamic      = (b_dprot != '0);
  assign cmd.address         = b_addr;
  assign cmd.source_address  = b_src;
  assign cmd.write_data      = b_data;
  assign cmd.copy_length     = b_len;

endmodule

// ===== rtl/sma_queue.sv =====
// Command queue between front and back end, register based.
// Depends on sma_pkg.
module sma_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  input  sma_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output sma_pkg::cmd_t head
);

  localparam int Depth = sma_pkg::QUEUE_DEPTH;
  localparam int PW    = $clog2(Depth);
  localparam int CW    = $clog2(Depth + 1);

  sma_pkg::cmd_t  entries [Depth];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign full       = (count == CW'(Depth));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign do_push    = push_valid && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(Depth - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(Depth - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== rtl/sma_back.sv =====
// Back end: sequences byte, word and copy accesses on the image RAM and
// holds the response register. Depends on sma_pkg and sma_ram.
module sma_back #(
  parameter int MEMORY_BYTES = sma_pkg::MEMORY_BYTES_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           head_valid,
  input  sma_pkg::cmd_t                  head,
  output logic                           pop,
  output logic                           busy,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output logic [sma_pkg::STATUS_W-1:0]   status,
  output logic [sma_pkg::DATA_W-1:0]     read_data,
  output logic                           in_dynamic
);

  localparam int AW = $clog2(MEMORY_BYTES);
  localparam int BY = sma_pkg::BYTE_W;
  localparam int DW = sma_pkg::DATA_W;
  localparam int LW = sma_pkg::LEN_W;

  typedef enum logic [4:0] {
    S_IDLE       = 5'b00001,
    S_WRITE_LOW  = 5'b00010,
    S_READ_LOW   = 5'b00100,
    S_COPY       = 5'b01000,
    S_DONE       = 5'b10000
  } state_t;

  state_t                        state;
  state_t                        state_next;
  sma_pkg::cmd_kind_t            cur_kind;
  logic [sma_pkg::STATUS_W-1:0]  cur_status;
  logic                          cur_dyn;
  logic [AW-1:0]                 wr_ptr;
  logic [AW-1:0]                 rd_ptr;
  logic [LW-1:0]                 remaining;
  logic [BY-1:0]                 lo_byte;
  logic [BY-1:0]                 hi_byte;
  logic                          rsp_free;

  logic                          we;
  logic [AW-1:0]                 waddr;
  logic [BY-1:0]                 wdata;
  logic                          re;
  logic [AW-1:0]                 raddr;
  logic [BY-1:0]                 rdata;

  sma_ram #(
    .WIDTH (BY),
    .DEPTH (MEMORY_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rsp_free = !rsp_valid || !rsp_stall;
  assign busy     = (state != S_IDLE);

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    we         = 1'b0;
    waddr      = wr_ptr;
    wdata      = lo_byte;
    re         = 1'b0;
    raddr      = rd_ptr;
    case (state)
      S_IDLE: begin
        if (head_valid) begin
          pop = 1'b1;
          case (head.kind)
            sma_pkg::CMD_WRITE_BYTE: begin
              we         = 1'b1;
              waddr      = AW'(head.address);
              wdata      = head.write_data[BY-1:0];
              state_next = S_DONE;
            end
            sma_pkg::CMD_WRITE_WORD: begin
              we         = 1'b1;
              waddr      = AW'(head.address);
              wdata      = head.write_data[DW-1:BY];
              state_next = S_WRITE_LOW;
            end
            sma_pkg::CMD_READ_BYTE: begin
              re         = 1'b1;
              raddr      = AW'(head.address);
              state_next = S_DONE;
            end
            sma_pkg::CMD_READ_WORD: begin
              re         = 1'b1;
              raddr      = AW'(head.address);
              state_next = S_READ_LOW;
            end
            sma_pkg::CMD_COPY: begin
              re         = 1'b1;
              raddr      = AW'(head.source_address);
              state_next = S_COPY;
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_WRITE_LOW: begin
        we         = 1'b1;
        state_next = S_DONE;
      end
      S_READ_LOW: begin
        re         = 1'b1;
        state_next = S_DONE;
      end
      S_COPY: begin
        // read of the next source byte overlaps the write; RAM forwards
        we    = 1'b1;
        wdata = rdata;
        if (remaining == LW'(1)) begin
          state_next = S_DONE;
        end else begin
          re = 1'b1;
        end
      end
      S_DONE: begin
        if (rsp_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == S_DONE) && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && head_valid) begin
      cur_kind   <= head.kind;
      cur_status <= head.status;
      cur_dyn    <= head.in_dynamic;
      lo_byte    <= head.write_data[BY-1:0];
      remaining  <= head.copy_length;
      if (head.kind == sma_pkg::CMD_COPY) begin
        wr_ptr <= AW'(head.address);
        rd_ptr <= AW'(head.source_address) + AW'(1);
      end else begin
        wr_ptr <= AW'(head.address) + AW'(1);
        rd_ptr <= AW'(head.address) + AW'(1);
      end
    end
    if (state == S_READ_LOW) begin
      hi_byte <= rdata;
    end
    if (state == S_COPY) begin
      wr_ptr    <= wr_ptr + AW'(1);
      rd_ptr    <= rd_ptr + AW'(1);
      remaining <= remaining - LW'(1);
    end
    if ((state == S_DONE) && rsp_free) begin
      status     <= cur_status;
      in_dynamic <= cur_dyn;
      case (cur_kind)
        sma_pkg::CMD_READ_BYTE: read_data <= {{(DW - BY){1'b0}}, rdata};
        sma_pkg::CMD_READ_WORD: read_data <= {hi_byte, rdata};
        default:                read_data <= '0;
      endcase
    end
  end

endmodule

// ===== rtl/split_memory_access_unit.sv =====
// Top level of the split memory access unit: configuration registers,
// front end, command queue and back end. Depends on sma_pkg and submodules.
//
//   channel   direction  handshake            payload
//   cfg       in         cfg_wr_en            cfg_index, cfg_data
//   request   in         req_valid/req_stall  operation, address, source_address,
//                                             write_data, copy_length
//   response  out        rsp_valid/rsp_stall  status, read_data, in_dynamic
//
// A request passes two check stages, then a 4-entry command queue.
// The back end's RAM sets the rate: a byte access or failed request passes idle
// and done, a word access adds a state, a copy loops in its state per byte.
// Reset clears control state and loads the register defaults; image RAM is
// not cleared and holds nothing valid until loaded.
// Requests stall only when both check stages and the queue are full.
module split_memory_access_unit #(
  parameter int MEMORY_BYTES = sma_pkg::MEMORY_BYTES_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic                           cfg_index,
  input  logic [sma_pkg::CFG_W-1:0]      cfg_data,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  logic [sma_pkg::OP_W-1:0]       operation,
  input  logic [sma_pkg::ADDR_W-1:0]     address,
  input  logic [sma_pkg::ADDR_W-1:0]     source_address,
  input  logic [sma_pkg::DATA_W-1:0]     write_data,
  input  logic [sma_pkg::LEN_W-1:0]      copy_length,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output logic [sma_pkg::STATUS_W-1:0]   status,
  output logic [sma_pkg::DATA_W-1:0]     read_data,
  output logic                           in_dynamic
);

`include "assert_macros.svh"

  logic [sma_pkg::BASE_W-1:0]  static_base;
  logic [sma_pkg::SIZE_W-1:0]  image_size;
  logic                        cmd_valid;
  sma_pkg::cmd_t               cmd;
  logic                        cmd_full;
  logic                        head_valid;
  sma_pkg::cmd_t               head;
  logic                        pop;
  logic                        back_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      static_base <= sma_pkg::STATIC_BASE_RESET;
      image_size  <= sma_pkg::IMAGE_SIZE_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        sma_pkg::CFG_STATIC_BASE: static_base <= cfg_data[sma_pkg::BASE_W-1:0];
        sma_pkg::CFG_IMAGE_SIZE:  image_size  <= cfg_data[sma_pkg::SIZE_W-1:0];
        default: begin
          static_base <= static_base;
        end
      endcase
    end
  end

  sma_front #(
    .MEMORY_BYTES (MEMORY_BYTES)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .operation      (operation),
    .address        (address),
    .source_address (source_address),
    .write_data     (write_data),
    .copy_length    (copy_length),
    .static_base    (static_base),
    .image_size     (image_size),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .cmd_full       (cmd_full)
  );

  sma_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (cmd_valid),
    .push_data  (cmd),
    .full       (cmd_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  sma_back #(
    .MEMORY_BYTES (MEMORY_BYTES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .busy       (back_busy),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .status     (status),
    .read_data  (read_data),
    .in_dynamic (in_dynamic)
  );

  `SMA_ASSERT_IMPL(a_err_no_data, clk, rst, rsp_valid && (status != sma_pkg::ST_OK), read_data == '0)
  `SMA_ASSERT_NEXT(a_front_holds, clk, rst, cmd_valid && cmd_full, cmd_valid)
  `SMA_ASSERT_NEXT(a_back_starts, clk, rst, head_valid && !back_busy, back_busy)

endmodule
